// ===== sv/smr90_pkg.sv =====
// Shared package of the square matrix rotate unit.
// Holds widths, command codes and the controller/datapath interface structs.
// No dependencies.
package smr90_pkg;

    // Default largest side of the matrix held in the cell store.
    localparam int MAX_SIDE_DEF = 16;

    // Fixed widths of the item fields and of the side register.
    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 2;
    localparam int IDX_PORT_W = 4;
    localparam int CFG_W      = 5;

    // Side register value after reset.
    localparam logic [CFG_W-1:0] SIDE_RESET = 5'd16;

    // Configuration port: one 32-bit register at byte address 0.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_MATRIX_SIDE = 1'b0;

    // Command codes of an item.
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ROTATE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    // Corners of one four-way swap, in the order they are read and written.
    typedef logic [1:0] corner_t;
    localparam corner_t CORNER_TOP    = 2'd0;
    localparam corner_t CORNER_LEFT   = 2'd1;
    localparam corner_t CORNER_BOTTOM = 2'd2;
    localparam corner_t CORNER_RIGHT  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    port_wr;       // store the item's value at its row and column
        logic    port_rd;       // read the cell at the item's row and column
        logic    rot_rd;        // read one corner of the current swap group
        logic    rot_wr;        // write one corner of the current swap group
        corner_t corner;        // corner addressed by rot_rd or rot_wr
        logic    out_load;      // load the output register with a result
        logic    res_status;    // status of that result
        logic    res_from_ram;  // result value comes from the store read data
    } smr90_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic idx_bad;     // the item's row or column is outside the active side
        logic side_small;  // active side is zero or one
    } smr90_stat_t;

endpackage

// ===== sv/square_matrix_rotate_90_unit.sv =====
// Top level of the square matrix rotate unit.
// Depends on smr90_pkg, smr90_ctrl and smr90_dpath.
//
// This block keeps a MAX_SIDE by MAX_SIDE matrix of signed 32-bit cells in a
// single RAM and takes one item at a time: a write stores cell_value at
// (row_index, col_index), a read returns the cell there, and a rotate turns
// the active matrix_side by matrix_side matrix 90 degrees clockwise in place.
// Every item gives exactly one result; read_value is zero for anything but a
// successful read, and status is 1 when a read or write names a row or column
// at or beyond the active side (such a write stores nothing). Function code 3
// does nothing and returns zero with status 0. The active side is the
// matrix_side register at byte address 0, saturated to MAX_SIDE; sizes zero
// and one make a rotate a no-op. Cells come out of reset undefined, so read
// only cells that have been written. Timing: a write, a refused item, a no-op
// or a trivial rotate is taken every cycle while the output register drains;
// a read passes through the finish state because the RAM read is registered.
// A rotate walks the matrix ring by ring in four-way swaps, reading all four
// corners and then writing them, at one RAM read or one RAM write per cycle,
// and in_ready stays low for all of that time but the accepting cycle. A
// result waits in the output register, and the block takes a new item while
// it waits; only a second result has to wait for the first to leave.
module square_matrix_rotate_90_unit #(
    parameter int MAX_SIDE = smr90_pkg::MAX_SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [smr90_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [smr90_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [smr90_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    // Input items.
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [smr90_pkg::FUNC_W-1:0]        func,
    input  logic [smr90_pkg::IDX_PORT_W-1:0]    row_index,
    input  logic [smr90_pkg::IDX_PORT_W-1:0]    col_index,
    input  logic signed [smr90_pkg::DATA_W-1:0] cell_value,
    // Result items.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [smr90_pkg::DATA_W-1:0] read_value,
    output logic                                status
);

    import smr90_pkg::*;

    localparam int IDX_W = $clog2(MAX_SIDE);

    smr90_cmd_t       cmd;
    smr90_stat_t      stat;
    logic [IDX_W-1:0] rot_ring;
    logic [IDX_W-1:0] rot_col;
    logic [IDX_W-1:0] rot_last;

    // The register port never stalls.
    assign pready = 1'b1;

    // The controller sequences items and the rotation walk; the datapath
    // owns the store, addressing and output register.
    smr90_ctrl #(
        .MAX_SIDE (MAX_SIDE)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .stat     (stat),
        .rot_last (rot_last),
        .cmd      (cmd),
        .rot_ring (rot_ring),
        .rot_col  (rot_col)
    );

    smr90_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .row_index  (row_index),
        .col_index  (col_index),
        .cell_value (cell_value),
        .cmd        (cmd),
        .rot_ring   (rot_ring),
        .rot_col    (rot_col),
        .stat       (stat),
        .rot_last   (rot_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status)
    );

endmodule

// ===== sv/smr90_ram.sv =====
// Generic single-clock RAM: one write port and one read port, registered read.
// No dependencies.
module smr90_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/smr90_ctrl.sv =====
// Controller of the square matrix rotate unit: item intake, the ring and
// column walk of a rotation, and result hand-off. Depends on smr90_pkg.
module smr90_ctrl #(
    parameter int MAX_SIDE = smr90_pkg::MAX_SIDE_DEF,
    localparam int IDX_W   = $clog2(MAX_SIDE)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [smr90_pkg::FUNC_W-1:0]  func,
    input  smr90_pkg::smr90_stat_t        stat,
    input  logic [IDX_W-1:0]              rot_last,
    output smr90_pkg::smr90_cmd_t         cmd,
    output logic [IDX_W-1:0]              rot_ring,
    output logic [IDX_W-1:0]              rot_col
);

    import smr90_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ROT_RD = 4'b0010,
        ST_ROT_WR = 4'b0100,
        ST_FINISH = 4'b1000
    } smr90_state_t;

    smr90_state_t     state_reg, state_next;
    corner_t          sub_reg, sub_next;
    logic [IDX_W-1:0] ring_reg, ring_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] far_reg, far_next;
    logic             res_status_reg, res_status_next;
    logic             from_ram_reg, from_ram_next;

    logic             imm;
    logic             imm_status;
    logic [IDX_W:0]   col_inc;
    logic [IDX_W:0]   ring_inc;
    logic [IDX_W-1:0] far_dec;

    assign col_inc  = {1'b0, col_reg} + (IDX_W+1)'(1);
    assign ring_inc = {1'b0, ring_reg} + (IDX_W+1)'(1);
    assign far_dec  = far_reg - IDX_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        sub_next        = sub_reg;
        ring_next       = ring_reg;
        col_next        = col_reg;
        far_next        = far_reg;
        res_status_next = res_status_reg;
        from_ram_next   = from_ram_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        imm             = 1'b0;
        imm_status      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (func)
                        FUNC_WRITE:
                        begin
                            cmd.port_wr = !stat.idx_bad;
                            imm         = 1'b1;
                            imm_status  = stat.idx_bad;
                        end
                        FUNC_READ:
                        begin
                            if (stat.idx_bad)
                            begin
                                imm        = 1'b1;
                                imm_status = 1'b1;
                            end
                            else
                            begin
                                cmd.port_rd     = 1'b1;
                                res_status_next = 1'b0;
                                from_ram_next   = 1'b1;
                                state_next      = ST_FINISH;
                            end
                        end
                        FUNC_ROTATE:
                        begin
                            if (stat.side_small)
                            begin
                                imm = 1'b1;
                            end
                            else
                            begin
                                ring_next  = '0;
                                col_next   = '0;
                                far_next   = rot_last;
                                sub_next   = CORNER_TOP;
                                state_next = ST_ROT_RD;
                            end
                        end
                        default:
                        begin
                            imm = 1'b1;
                        end
                    endcase

                    // Items that finish at once go straight to the output
                    // register when it has room, otherwise they wait.
                    if (imm)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.res_status = imm_status;
                        end
                        else
                        begin
                            res_status_next = imm_status;
                            from_ram_next   = 1'b0;
                            state_next      = ST_FINISH;
                        end
                    end
                end
            end
            ST_ROT_RD:
            begin
                cmd.rot_rd = 1'b1;
                cmd.corner = sub_reg;
                sub_next   = corner_t'(sub_reg + 2'd1);
                if (sub_reg == CORNER_RIGHT)
                begin
                    state_next = ST_ROT_WR;
                end
            end
            ST_ROT_WR:
            begin
                cmd.rot_wr = 1'b1;
                cmd.corner = sub_reg;
                sub_next   = corner_t'(sub_reg + 2'd1);
                if (sub_reg == CORNER_RIGHT)
                begin
                    if (col_inc < {1'b0, far_reg})
                    begin
                        col_next   = col_inc[IDX_W-1:0];
                        state_next = ST_ROT_RD;
                    end
                    else if (ring_inc < {1'b0, far_dec})
                    begin
                        ring_next  = ring_inc[IDX_W-1:0];
                        col_next   = ring_inc[IDX_W-1:0];
                        far_next   = far_dec;
                        state_next = ST_ROT_RD;
                    end
                    else
                    begin
                        res_status_next = 1'b0;
                        from_ram_next   = 1'b0;
                        state_next      = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.res_status   = res_status_reg;
                    cmd.res_from_ram = from_ram_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sub_reg        <= CORNER_TOP;
            ring_reg       <= '0;
            col_reg        <= '0;
            far_reg        <= '0;
            res_status_reg <= 1'b0;
            from_ram_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sub_reg        <= sub_next;
            ring_reg       <= ring_next;
            col_reg        <= col_next;
            far_reg        <= far_next;
            res_status_reg <= res_status_next;
            from_ram_reg   <= from_ram_next;
        end
    end

    assign rot_ring = ring_reg;
    assign rot_col  = col_reg;

endmodule

// ===== sv/smr90_dpath.sv =====
// Datapath of the square matrix rotate unit: side register and its port,
// cell store, corner addressing, swap buffer and output register.
// Depends on smr90_pkg and smr90_ram.
module smr90_dpath #(
    parameter int MAX_SIDE = smr90_pkg::MAX_SIDE_DEF,
    localparam int IDX_W   = $clog2(MAX_SIDE)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [smr90_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [smr90_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [smr90_pkg::APB_DATA_W-1:0]    prdata,
    input  logic [smr90_pkg::IDX_PORT_W-1:0]    row_index,
    input  logic [smr90_pkg::IDX_PORT_W-1:0]    col_index,
    input  logic signed [smr90_pkg::DATA_W-1:0] cell_value,
    input  smr90_pkg::smr90_cmd_t               cmd,
    input  logic [IDX_W-1:0]                    rot_ring,
    input  logic [IDX_W-1:0]                    rot_col,
    output smr90_pkg::smr90_stat_t              stat,
    output logic [IDX_W-1:0]                    rot_last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [smr90_pkg::DATA_W-1:0] read_value,
    output logic                                status
);

    import smr90_pkg::*;

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_SIDE) + ADDR_W'(c);
    endfunction

    logic [CFG_W-1:0]  side_reg;
    logic [CFG_W-1:0]  act_side;
    logic              reg_hit;

    logic [IDX_W-1:0]  far;
    logic [IDX_W-1:0]  mirror;
    logic [IDX_W-1:0]  crn_row;
    logic [IDX_W-1:0]  crn_col;
    logic [ADDR_W-1:0] port_addr;
    logic [ADDR_W-1:0] crn_addr;

    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    logic [DATA_W-1:0] swap_reg [4];
    logic [DATA_W-1:0] swap_wdata;
    logic              cap_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic              status_reg;

    // Side register.
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_MATRIX_SIDE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            side_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata   = reg_hit ? APB_DATA_W'(side_reg) : '0;
    assign act_side = (int'(side_reg) > MAX_SIDE) ? CFG_W'(MAX_SIDE) : side_reg;
    assign rot_last = IDX_W'(act_side - CFG_W'(1));

    assign stat.idx_bad    = ({1'b0, row_index} >= act_side) ||
                             ({1'b0, col_index} >= act_side);
    assign stat.side_small = (act_side < CFG_W'(2));
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Corner of the current swap group.
    assign far    = rot_last - rot_ring;
    assign mirror = rot_last - rot_col;

    always_comb
    begin
        case (cmd.corner)
            CORNER_TOP:
            begin
                crn_row = rot_ring;
                crn_col = rot_col;
            end
            CORNER_LEFT:
            begin
                crn_row = mirror;
                crn_col = rot_ring;
            end
            CORNER_BOTTOM:
            begin
                crn_row = far;
                crn_col = mirror;
            end
            default:
            begin
                crn_row = rot_col;
                crn_col = far;
            end
        endcase
    end

    assign crn_addr  = cell_addr(crn_row, crn_col);
    assign port_addr = cell_addr(IDX_W'(row_index), IDX_W'(col_index));

    // Each corner takes the value of the next corner counterclockwise. The
    // top corner is written while the right corner is still shifting in, so
    // at that cycle the left value sits one place further up the buffer.
    always_comb
    begin
        case (cmd.corner)
            CORNER_TOP:    swap_wdata = swap_reg[2];
            CORNER_LEFT:   swap_wdata = swap_reg[2];
            CORNER_BOTTOM: swap_wdata = swap_reg[3];
            default:       swap_wdata = swap_reg[0];
        endcase
    end

    assign ram_we    = cmd.port_wr || cmd.rot_wr;
    assign ram_re    = cmd.port_rd || cmd.rot_rd;
    assign ram_waddr = cmd.port_wr ? port_addr : crn_addr;
    assign ram_raddr = cmd.port_rd ? port_addr : crn_addr;
    assign ram_wdata = cmd.port_wr ? cell_value : swap_wdata;

    smr90_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Corner read data arrives in the cycle after the read and shifts into the
    // swap buffer, which then holds top, left, bottom, right in that order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 1'b0;
        end
        else
        begin
            cap_reg <= cmd.rot_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_reg)
        begin
            swap_reg[0] <= swap_reg[1];
            swap_reg[1] <= swap_reg[2];
            swap_reg[2] <= swap_reg[3];
            swap_reg[3] <= ram_rdata;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            read_value_reg <= cmd.res_from_ram ? ram_rdata : '0;
            status_reg     <= cmd.res_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

endmodule
